// ===== hdl/ezw_pkg.sv =====
// Shared types, constants and register indexes for the energy and crossing wake detector.
package ezw_pkg;

  localparam int MAX_FRAME_SAMPLES_DEF = 512;

  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;
  localparam int ENERGY_W = 48;
  localparam int CROSS_W  = 12;
  localparam int RUN_W    = 8;
  localparam int TARGET_W = 8;
  localparam int STAGE_W  = 16;
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 3;

  localparam int MID_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  localparam logic [ENERGY_W-1:0] ENERGY_THR_RST = 48'd2000000;
  localparam logic [CROSS_W-1:0]  CROSS_THR_RST  = 12'd15;
  localparam logic [RUN_W-1:0]    RUN_NEEDED_RST = 8'd2;
  localparam logic [TARGET_W-1:0] TARGET_RST     = 8'd3;

  localparam logic OPC_SAMPLE  = 1'b0;
  localparam logic OPC_RESTART = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_ENERGY_THR   = 3'd1,
    REG_CROSS_THR    = 3'd2,
    REG_RUN_NEEDED   = 3'd3,
    REG_STAGE_TARGET = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_LISTENING = 2'd1,
    MODE_CAPTURING = 2'd2
  } mode_t;

  // Work classes assigned by the front end.
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_RESTART = 2'd1,
    OP_REJECT  = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic                       opcode;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
  } item_t;

  typedef struct packed {
    logic                status;
    logic                frame_active;
    logic                wake_pulse;
    mode_t               mode;
    logic [ENERGY_W-1:0] frame_energy;
    logic [CROSS_W-1:0]  crossings;
    logic [STAGE_W-1:0]  stage_count;
  } result_t;

  typedef struct packed {
    op_kind_t        kind;
    logic [SQ_W-1:0] sq;
    logic            neg;
    logic            fend;
  } op_t;

  // Closed frame (OP_SAMPLE), restart or reject on its way to the decision stage.
  typedef struct packed {
    op_kind_t            kind;
    logic [ENERGY_W-1:0] energy;
    logic [CROSS_W-1:0]  crossings;
  } frame_rec_t;

  typedef struct packed {
    logic                enable;
    logic [ENERGY_W-1:0] energy_thr;
    logic [CROSS_W-1:0]  cross_thr;
    logic [RUN_W-1:0]    run_needed;
    logic [TARGET_W-1:0] stage_target;
  } cfg_t;

  typedef struct packed {
    logic disable_det;
    logic reinit;
  } cfg_evt_t;

endpackage

// ===== hdl/energy_zcr_wake_detector.sv =====
// Top level of the energy and zero-crossing wake detector.
//
// Samples enter through a queue-style port (push/full) and per-frame results leave
// through another (empty/pop). While the result queue has room, the block takes one
// item every clock cycle: the sustained rate is set by the frame accumulator, which
// folds one squared sample into the 48-bit saturating energy sum and the crossing
// count each cycle. A front stage classifies each item (sample, restart, or reject
// while disabled) and registers the 16x16 square; a four-entry queue decouples it
// from the back end, where an accumulator stage closes frames and a decision stage
// applies the energy and crossing thresholds, the active-run count and the wake
// stage counter. A frame closes on frame_end or its MAX_FRAME_SAMPLES-th sample;
// its result passes the front register, middle queue and decision register to the
// output queue. Restart items and disabled samples without frame_end produce no
// result. Results wait in a four-entry queue; when it fills, the back end and then
// the front stall. The configuration port is always ready and must only be written
// while the block is idle; there is no clearing pass after reset.
module energy_zcr_wake_detector #(
  parameter int MAX_FRAME_SAMPLES = ezw_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  ezw_pkg::item_t                     item,
  output logic                               full,
  output logic                               empty,
  input  logic                               pop,
  output ezw_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ezw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ezw_pkg::CFG_W-1:0]          cfg_data
);
  import ezw_pkg::*;

  cfg_t     cfg;
  cfg_evt_t evt;
  logic     cfg_wr;

  logic     op_valid;
  op_t      op;
  logic     mid_full;
  logic     mid_empty;
  op_t      mid_op;
  logic     mid_pop;

  logic     res_push;
  result_t  res_data;
  logic     res_full;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Enable writes: a clear drops to idle, a set from disabled re-arms everything.
  always_comb begin
    evt = '0;
    if (cfg_wr && (cfg_index == REG_ENABLE)) begin
      evt.disable_det = !cfg_data[0];
      evt.reinit      = cfg_data[0] && !cfg.enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= 1'b1;
      cfg.energy_thr   <= ENERGY_THR_RST;
      cfg.cross_thr    <= CROSS_THR_RST;
      cfg.run_needed   <= RUN_NEEDED_RST;
      cfg.stage_target <= TARGET_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_ENABLE:       cfg.enable       <= cfg_data[0];
        REG_ENERGY_THR:   cfg.energy_thr   <= cfg_data[ENERGY_W-1:0];
        REG_CROSS_THR:    cfg.cross_thr    <= cfg_data[CROSS_W-1:0];
        REG_RUN_NEEDED:   cfg.run_needed   <= cfg_data[RUN_W-1:0];
        REG_STAGE_TARGET: cfg.stage_target <= cfg_data[TARGET_W-1:0];
        default:          cfg.enable       <= cfg.enable;
      endcase
    end
  end

  // Classify and square.
  ezw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .enable   (cfg.enable),
    .op_valid (op_valid),
    .op       (op),
    .op_full  (mid_full)
  );

  // Hold classified items between front and back.
  ezw_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (op_valid),
    .wdata (op),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_op),
    .empty (mid_empty)
  );

  // Accumulate frames and advance the wake logic.
  ezw_back #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .evt        (evt),
    .in_valid   (!mid_empty),
    .in_op      (mid_op),
    .in_pop     (mid_pop),
    .out_push   (res_push),
    .out_result (res_data),
    .out_full   (res_full)
  );

  // Hold finished results until taken.
  ezw_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// ===== hdl/ezw_fifo.sv =====
// Small register queue with show-ahead read, used between the stages and at the output.
module ezw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ===== hdl/ezw_front.sv =====
// Front end: accept items, classify them and square the sample magnitude.
module ezw_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ezw_pkg::item_t item,
  output logic           full,
  input  logic           enable,
  output logic           op_valid,
  output ezw_pkg::op_t   op,
  input  logic           op_full
);
  import ezw_pkg::*;

  logic [SAMPLE_W-1:0] raw;
  logic [SAMPLE_W-1:0] mag;
  logic [31:0]         prod;
  logic                take;
  logic                keep;
  op_kind_t            kind;

  assign raw  = item.sample;
  assign mag  = raw[SAMPLE_W-1] ? SAMPLE_W'(~raw + 16'd1) : raw;
  assign prod = 32'(mag) * 32'(mag);
  assign full = op_valid && op_full;
  assign take = push && !full;

  always_comb begin
    // Drop disabled samples that close nothing: they touch no state.
    kind = OP_SAMPLE;
    keep = 1'b1;
    if (item.opcode == OPC_RESTART) begin
      kind = OP_RESTART;
    end else if (!enable) begin
      kind = OP_REJECT;
      keep = item.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (!full) begin
      op_valid <= take && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op.kind <= kind;
      op.sq   <= prod[SQ_W-1:0];
      op.neg  <= raw[SAMPLE_W-1];
      op.fend <= item.frame_end;
    end
  end

endmodule

// ===== hdl/ezw_back.sv =====
// Back end: frame accumulation, then the activity decision and wake stage counter.
module ezw_back #(
  parameter int MAX_FRAME_SAMPLES = ezw_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ezw_pkg::cfg_t      cfg,
  input  ezw_pkg::cfg_evt_t  evt,
  input  logic               in_valid,
  input  ezw_pkg::op_t       in_op,
  output logic               in_pop,
  output logic               out_push,
  output ezw_pkg::result_t   out_result,
  input  logic               out_full
);
  import ezw_pkg::*;

  localparam int LEN_W = $clog2(MAX_FRAME_SAMPLES + 1);

  // Accumulator stage state.
  logic [ENERGY_W-1:0] energy_sum;
  logic [CROSS_W-1:0]  crossing_count;
  logic                prev_negative;
  logic                frame_started;
  logic [LEN_W-1:0]    frame_len;

  logic [ENERGY_W:0]   e_acc;
  logic [ENERGY_W-1:0] e_new;
  logic [CROSS_W-1:0]  c_new;
  logic [LEN_W-1:0]    len_new;
  logic                closes;
  logic                s1_go;
  logic                s1_emit;

  // Decision stage.
  logic                s2_valid;
  frame_rec_t          s2_rec;
  logic                s2_ready;
  logic                s2_go;

  logic [RUN_W-1:0]    active_run;
  logic [STAGE_W-1:0]  stage_counter;
  mode_t               mode;

  logic                active;
  logic [RUN_W-1:0]    run_inc;
  logic [STAGE_W-1:0]  sc_inc;
  logic [STAGE_W-1:0]  sc_dec;
  logic                advance;
  logic                hit;
  logic [RUN_W-1:0]    run_n;
  logic [STAGE_W-1:0]  sc_n;
  logic                wake;
  mode_t               mode_n;

  assign s2_ready = !s2_valid || !out_full;
  assign s2_go    = s2_valid && !out_full;
  assign s1_go    = in_valid && s2_ready;
  assign in_pop   = s1_go;

  always_comb begin
    e_acc = {1'b0, energy_sum} + (ENERGY_W + 1)'(in_op.sq);
    if (!frame_started) begin
      e_new   = ENERGY_W'(in_op.sq);
      c_new   = '0;
      len_new = LEN_W'(1);
    end else begin
      e_new   = e_acc[ENERGY_W] ? '1 : e_acc[ENERGY_W-1:0];
      c_new   = crossing_count;
      if ((in_op.neg != prev_negative) && !(&crossing_count)) begin
        c_new = crossing_count + CROSS_W'(1);
      end
      len_new = (frame_len < LEN_W'(MAX_FRAME_SAMPLES)) ? frame_len + LEN_W'(1) : frame_len;
    end
    // Force a close when the frame runs long.
    closes  = in_op.fend || (len_new >= LEN_W'(MAX_FRAME_SAMPLES));
    s1_emit = s1_go && ((in_op.kind != OP_SAMPLE) || closes);
  end

  always_ff @(posedge clk) begin
    if (rst || evt.reinit) begin
      energy_sum     <= '0;
      crossing_count <= '0;
      prev_negative  <= 1'b0;
      frame_started  <= 1'b0;
      frame_len      <= '0;
    end else if (s1_go) begin
      if ((in_op.kind == OP_SAMPLE) && !closes) begin
        energy_sum     <= e_new;
        crossing_count <= c_new;
        prev_negative  <= in_op.neg;
        frame_started  <= 1'b1;
        frame_len      <= len_new;
      end else begin
        energy_sum     <= '0;
        crossing_count <= '0;
        prev_negative  <= 1'b0;
        frame_started  <= 1'b0;
        frame_len      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      s2_rec.kind      <= in_op.kind;
      s2_rec.energy    <= e_new;
      s2_rec.crossings <= c_new;
    end
  end

  always_comb begin
    active  = (s2_rec.energy > cfg.energy_thr) && (s2_rec.crossings > cfg.cross_thr);
    run_inc = (&active_run) ? active_run : active_run + RUN_W'(1);
    sc_inc  = (&stage_counter) ? stage_counter : stage_counter + STAGE_W'(1);
    sc_dec  = (stage_counter == '0) ? stage_counter : stage_counter - STAGE_W'(1);
    advance = (run_inc >= cfg.run_needed);
    hit     = (sc_inc >= STAGE_W'(cfg.stage_target));
    run_n   = '0;
    sc_n    = sc_dec;
    wake    = 1'b0;
    mode_n  = mode;
    if (active) begin
      run_n = run_inc;
      sc_n  = stage_counter;
      if (advance) begin
        sc_n = sc_inc;
        if (hit) begin
          wake   = 1'b1;
          mode_n = MODE_CAPTURING;
        end
      end
    end

    out_result = '0;
    case (s2_rec.kind)
      OP_SAMPLE: begin
        out_result.frame_active = active;
        out_result.wake_pulse   = wake;
        out_result.mode         = mode_n;
        out_result.frame_energy = s2_rec.energy;
        out_result.crossings    = s2_rec.crossings;
        out_result.stage_count  = sc_n;
      end
      default: begin
        out_result.status      = 1'b1;
        out_result.mode        = MODE_IDLE;
        out_result.stage_count = stage_counter;
      end
    endcase
    out_push = s2_go && (s2_rec.kind != OP_RESTART);
  end

  always_ff @(posedge clk) begin
    if (rst || evt.reinit) begin
      active_run    <= '0;
      stage_counter <= '0;
      mode          <= MODE_LISTENING;
    end else if (evt.disable_det) begin
      mode <= MODE_IDLE;
    end else if (s2_go) begin
      case (s2_rec.kind)
        OP_SAMPLE: begin
          active_run    <= run_n;
          stage_counter <= sc_n;
          mode          <= mode_n;
        end
        OP_RESTART: begin
          active_run    <= '0;
          stage_counter <= '0;
          mode          <= cfg.enable ? MODE_LISTENING : MODE_IDLE;
        end
        default: begin
          mode <= mode;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    frame_len <= LEN_W'(MAX_FRAME_SAMPLES))
    else $error("frame length beyond limit");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_go && (in_op.kind == OP_SAMPLE) && closes) |=> !frame_started)
    else $error("closed frame left accumulator open");

  a_idle_when_off: assert property (@(posedge clk) disable iff (rst)
    !cfg.enable |-> (mode == MODE_IDLE))
    else $error("detector not idle while disabled");

  a_stage_step: assert property (@(posedge clk) disable iff (rst)
    (!(s2_go && (s2_rec.kind == OP_RESTART)) && !evt.reinit) |=>
      ((stage_counter == $past(stage_counter)) ||
       (stage_counter == $past(stage_counter) + 16'd1) ||
       (stage_counter == $past(stage_counter) - 16'd1)))
    else $error("stage counter moved by more than one");
`endif

endmodule

// ===== bench/energy_zcr_wake_detector_tb.sv =====
// Self-checking bench for the energy and zero-crossing wake detector: queued stimulus, clocked driver and monitor, frame verdict predictor.
module energy_zcr_wake_detector_tb;
  import ezw_pkg::*;

  localparam int FRAME_CAP      = MAX_FRAME_SAMPLES_DEF;
  localparam int SETTLE_CYCLES  = 12;    // margin for the pipe to go quiet after the last verdict
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any handshake
  localparam int SEGMENTS       = 12;
  localparam int SEGMENT_ITEMS  = 20;

  typedef enum int {FR_VOICED, FR_QUIET, FR_NOISE} frame_flavor_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  item_t   item_bus = '0;
  logic    full;
  logic    empty;
  logic    pop = 1'b0;
  result_t result_bus;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Items waiting for the driver, and verdicts waiting for the monitor.
  item_t   samples_to_send[$];
  result_t frame_verdicts_due[$];

  int items_planned = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  // Predictor state: a private copy of the registers and of the detector.
  cfg_t         cfg_model;
  logic [47:0]  energy_acc;
  logic [11:0]  cross_acc;
  logic         prev_neg;
  logic         in_frame;
  int           frame_len;
  logic [7:0]   active_run;
  logic [15:0]  stage_cnt;
  mode_t        mode_q;

  always #1 clk = ~clk;

  energy_zcr_wake_detector #(
    .MAX_FRAME_SAMPLES(FRAME_CAP)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .item(item_bus),
    .full(full),
    .empty(empty),
    .pop(pop),
    .result(result_bus),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic clear_frame_acc();
    energy_acc = '0;
    cross_acc  = '0;
    prev_neg   = 1'b0;
    in_frame   = 1'b0;
    frame_len  = 0;
  endtask

  task automatic clear_detector_counts();
    clear_frame_acc();
    active_run = '0;
    stage_cnt  = '0;
  endtask

  // Mirror a register write as the block sees it.
  task automatic track_register_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    case (cfg_reg_t'(idx))
      REG_ENABLE: begin
        // Dropping enable only idles the mode; raising it from off re-initializes.
        if (!d[0]) begin
          mode_q = MODE_IDLE;
        end else if (!cfg_model.enable) begin
          clear_detector_counts();
          mode_q = MODE_LISTENING;
        end
        cfg_model.enable = d[0];
      end
      REG_ENERGY_THR:   cfg_model.energy_thr   = d[ENERGY_W-1:0];
      REG_CROSS_THR:    cfg_model.cross_thr    = d[CROSS_W-1:0];
      REG_RUN_NEEDED:   cfg_model.run_needed   = d[RUN_W-1:0];
      REG_STAGE_TARGET: cfg_model.stage_target = d[TARGET_W-1:0];
      default: ;
    endcase
  endtask

  // Advance the detector by one accepted item; queue a verdict when a frame closes.
  task automatic predict_frame_verdict(item_t it);
    logic        neg;
    logic [16:0] mag;
    logic [33:0] sq;
    logic [48:0] sum;
    logic        active;
    logic        wake;
    result_t     r;
    neg = it.sample[SAMPLE_W-1];
    mag = neg ? (17'h10000 - {1'b0, it.sample}) : {1'b0, it.sample};
    sq  = mag * mag;
    r   = '0;
    if (it.opcode == OPC_RESTART) begin
      // Restart: wipe everything, mode follows enable, no verdict.
      clear_detector_counts();
      mode_q = cfg_model.enable ? MODE_LISTENING : MODE_IDLE;
    end else if (!cfg_model.enable) begin
      // Disabled: only a frame_end counts, and it is rejected.
      if (it.frame_end) begin
        clear_frame_acc();
        r.status      = 1'b1;
        r.mode        = MODE_IDLE;
        r.stage_count = stage_cnt;
        frame_verdicts_due.push_back(r);
      end
    end else begin
      if (!in_frame) begin
        energy_acc = 48'(sq);
        cross_acc  = '0;
        frame_len  = 1;
        in_frame   = 1'b1;
      end else begin
        sum = {1'b0, energy_acc} + 49'(sq);
        energy_acc = sum[48] ? '1 : sum[47:0];
        if (neg != prev_neg && cross_acc != '1) cross_acc++;
        if (frame_len < FRAME_CAP) frame_len++;
      end
      prev_neg = neg;
      // A frame closes on frame_end or when it hits the length cap.
      if (it.frame_end || frame_len >= FRAME_CAP) begin
        active = (energy_acc > cfg_model.energy_thr) && (cross_acc > cfg_model.cross_thr);
        wake   = 1'b0;
        if (active) begin
          if (active_run != '1) active_run++;
          if (active_run >= cfg_model.run_needed) begin
            if (stage_cnt != '1) stage_cnt++;
            if (stage_cnt >= {8'd0, cfg_model.stage_target}) begin
              wake   = 1'b1;
              mode_q = MODE_CAPTURING;
            end
          end
        end else begin
          if (stage_cnt != '0) stage_cnt--;
          active_run = '0;
        end
        r.frame_active = active;
        r.wake_pulse   = wake;
        r.mode         = mode_q;
        r.frame_energy = energy_acc;
        r.crossings    = cross_acc;
        r.stage_count  = stage_cnt;
        frame_verdicts_due.push_back(r);
        clear_frame_acc();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the head of the item queue, advance on acceptance
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : driver
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_frame_verdict(item_bus);
        void'(samples_to_send.pop_front());
      end
      // Hold push through full; drop it when the queue is empty or for a random send gap.
      if (samples_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        push     <= 1'b1;
        item_bus <= samples_to_send[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each popped item with the oldest verdict
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (frame_verdicts_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, result_bus);
          mismatches++;
        end else begin
          want = frame_verdicts_due.pop_front();
          check_field("status",       64'(want.status),       64'(result_bus.status));
          check_field("frame_active", 64'(want.frame_active), 64'(result_bus.frame_active));
          check_field("wake_pulse",   64'(want.wake_pulse),   64'(result_bus.wake_pulse));
          check_field("mode",         64'(want.mode),         64'(result_bus.mode));
          check_field("frame_energy", 64'(want.frame_energy), 64'(result_bus.frame_energy));
          check_field("crossings",    64'(want.crossings),    64'(result_bus.crossings));
          check_field("stage_count",  64'(want.stage_count),  64'(result_bus.stage_count));
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Mirror register writes at the handshake.
  always @(posedge clk) begin : cfg_tracker
    if (!rst && cfg_valid && cfg_ready) begin
      track_register_write(cfg_index, cfg_data);
    end
  end

  // Stop a hung run: count cycles with no handshake on any port.
  always @(posedge clk) begin : watchdog
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_item(logic opc, logic [SAMPLE_W-1:0] s, logic fe);
    item_t it;
    it.opcode    = opc;
    it.sample    = s;
    it.frame_end = fe;
    samples_to_send.push_back(it);
    items_planned++;
  endtask

  // Queue one frame; a frame at the length cap may omit frame_end.
  task automatic add_frame(int len, frame_flavor_t flavor);
    logic                neg;
    int                  m;
    logic [SAMPLE_W-1:0] s;
    logic                fe;
    neg = 1'($urandom);
    for (int n = 1; n <= len; n++) begin
      case (flavor)
        FR_VOICED: begin
          // Loud and mostly alternating in sign.
          m = $urandom_range(32767, 200);
          s = neg ? 16'(-m) : 16'(m);
          if ($urandom_range(9) != 0) neg = !neg;
        end
        FR_QUIET: begin
          m = $urandom_range(300, 0);
          s = neg ? 16'(-m) : 16'(m);
          if ($urandom_range(9) == 0) neg = !neg;
        end
        default: s = 16'($urandom);
      endcase
      fe = (n == len) && !(len == FRAME_CAP && $urandom_range(1) == 0);
      add_item(OPC_SAMPLE, s, fe);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every item is in and every verdict is out, then let the pipe go quiet.
  task automatic drain_and_settle();
    while (samples_to_send.size() != 0 || push || frame_verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int pick;
    int len;
    int base;
    int m;
    logic [CFG_W-1:0] thr;

    cfg_model.enable       = 1'b1;
    cfg_model.energy_thr   = ENERGY_THR_RST;
    cfg_model.cross_thr    = CROSS_THR_RST;
    cfg_model.run_needed   = RUN_NEEDED_RST;
    cfg_model.stage_target = TARGET_RST;
    clear_detector_counts();
    mode_q = MODE_LISTENING;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset thresholds, sample extremes, single-sample frame, restart mid-frame.
    add_item(OPC_SAMPLE, 16'h7fff, 1'b0);
    add_item(OPC_SAMPLE, 16'h8000, 1'b1);
    add_item(OPC_SAMPLE, 16'h0000, 1'b1);
    add_item(OPC_SAMPLE, 16'hffff, 1'b0);
    add_item(OPC_RESTART, 16'($urandom), 1'b1);
    add_item(OPC_SAMPLE, 16'hffff, 1'b0);
    add_item(OPC_SAMPLE, 16'h0001, 1'b1);
    drain_and_settle();

    // Lowest thresholds: every crossing frame is active, wake fires again each frame.
    write_reg(REG_ENERGY_THR, '0);
    write_reg(REG_CROSS_THR, '0);
    write_reg(REG_RUN_NEEDED, CFG_W'(1));
    write_reg(REG_STAGE_TARGET, CFG_W'(1));
    repeat (3) begin
      add_item(OPC_SAMPLE, 16'd1000, 1'b0);
      add_item(OPC_SAMPLE, -16'sd1000, 1'b1);
    end
    add_item(OPC_SAMPLE, 16'd5, 1'b1);
    drain_and_settle();

    // Zero run and zero target compare as always met.
    write_reg(REG_RUN_NEEDED, '0);
    write_reg(REG_STAGE_TARGET, '0);
    add_item(OPC_SAMPLE, 16'h0000, 1'b1);
    add_item(OPC_SAMPLE, -16'sd7, 1'b0);
    add_item(OPC_SAMPLE, 16'd7, 1'b1);
    drain_and_settle();

    // Disabled: reject the frame, restart leaves mode idle.
    write_reg(REG_ENABLE, '0);
    add_item(OPC_SAMPLE, 16'd100, 1'b0);
    add_item(OPC_SAMPLE, 16'd200, 1'b1);
    add_item(OPC_RESTART, 16'($urandom), 1'b0);
    drain_and_settle();

    // Enable writes: off again, re-init, then a no-op; unused indexes do nothing.
    write_reg(REG_ENABLE, '0);
    write_reg(REG_ENABLE, CFG_W'(1));
    write_reg(REG_ENABLE, CFG_W'(1));
    for (int k = int'(REG_STAGE_TARGET) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(k[CFG_IDX_W-1:0], CFG_W'({$urandom, $urandom}));
    end

    // Highest thresholds: nothing can pass.
    write_reg(REG_ENERGY_THR, '1);
    write_reg(REG_CROSS_THR, '1);
    write_reg(REG_RUN_NEEDED, CFG_W'(255));
    write_reg(REG_STAGE_TARGET, CFG_W'(255));
    add_item(OPC_SAMPLE, 16'h7fff, 1'b0);
    add_item(OPC_SAMPLE, 16'h8000, 1'b1);
    drain_and_settle();

    // Long active run: the wake fires once the run reaches its need, then on every frame.
    send_gap_pct   = 26;
    recv_stall_pct = 26;
    write_reg(REG_ENERGY_THR, '0);
    write_reg(REG_CROSS_THR, '0);
    write_reg(REG_RUN_NEEDED, CFG_W'(30));
    write_reg(REG_STAGE_TARGET, CFG_W'(1));
    repeat (40) begin
      m = $urandom_range(32767, 1);
      add_item(OPC_SAMPLE, 16'(m), 1'b0);
      add_item(OPC_SAMPLE, 16'(-m), 1'b1);
    end
    drain_and_settle();

    // Random segments: fresh settings each, idling pattern rotating.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
        default: begin send_gap_pct = 26; recv_stall_pct = 26; end
      endcase

      write_reg(REG_ENABLE, ($urandom_range(9) == 0) ? CFG_W'(0) : CFG_W'(1));
      pick = $urandom_range(9);
      thr  = (pick == 0) ? '0 : (pick == 1) ? '1 : CFG_W'($urandom_range(40000000, 0));
      write_reg(REG_ENERGY_THR, thr);
      pick = $urandom_range(9);
      write_reg(REG_CROSS_THR,
                CFG_W'((pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(12, 0)));
      write_reg(REG_RUN_NEEDED,
                CFG_W'(($urandom_range(19) == 0) ? 255 : $urandom_range(3, 0)));
      write_reg(REG_STAGE_TARGET,
                CFG_W'(($urandom_range(19) == 0) ? 255 : $urandom_range(5, 0)));

      // One capped frame for sure in an early segment.
      if (seg == 1) add_frame(FRAME_CAP, FR_VOICED);

      base = items_planned;
      while (items_planned - base < SEGMENT_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          add_item(OPC_RESTART, 16'($urandom), 1'($urandom));
        end else if (pick < 10) begin
          // Stray sample: may split or merge frames.
          add_item(OPC_SAMPLE, 16'($urandom), 1'($urandom));
        end else begin
          len  = $urandom_range(24, 1);
          pick = $urandom_range(9);
          add_frame(len, (pick < 5) ? FR_VOICED : (pick < 8) ? FR_QUIET : FR_NOISE);
        end
      end
      drain_and_settle();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ezw_pkg.sv
hdl/ezw_fifo.sv
hdl/ezw_front.sv
hdl/ezw_back.sv
hdl/energy_zcr_wake_detector.sv
bench/energy_zcr_wake_detector_tb.sv
